@@ hw/rtl/gzt_pkg.sv @@
`default_nettype none
package gzt_pkg;

  localparam int MAX_FENCES = 4;
  localparam int FK_W = $clog2(MAX_FENCES);
  localparam int ANG_W = 35;
  localparam int COS_W = 34;
  localparam int CORDIC_ITERS = 30;

  typedef logic [1:0] zone_t;
  typedef logic [63:0] fpos_t;
  typedef logic [25:0] farea_t;

  localparam zone_t ZONE_HOME = 2'd0;
  localparam zone_t ZONE_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_KEEP = 2'd0,
    OP_SET  = 2'd1,
    OP_SCAN = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    zone_t              zone;
    logic signed [30:0] lat;
    logic signed [31:0] lng;
  } cmd_t;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [COS_W-1:0] cos;
  } cordic_rsp_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_FOLD,
    C_MUL,
    C_ITER
  } cstate_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FENCE,
    B_START,
    B_WAIT,
    B_P,
    B_Q,
    B_CMP
  } bstate_t;

  localparam logic [31:0] CHECK_MS = 32'd10000;
  localparam logic [31:0] OVERRIDE_MS = 32'd14400000;

  localparam logic signed [ANG_W-1:0] DEG_FULL = 35'sd3600000000;
  localparam logic signed [ANG_W-1:0] DEG_HALF = 35'sd1800000000;
  localparam logic signed [ANG_W-1:0] DEG_QUART = 35'sd900000000;
  localparam logic [24:0] RAD_Q24 = 25'd31441057;
  localparam logic [22:0] M_TO_DEG_Q16 = 23'd5893794;
  localparam logic signed [COS_W:0] ONE_Q30 = 35'sd1073741824;
  localparam logic signed [COS_W-1:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [COS_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [COS_W-1:0] v;
    begin
      case (i)
        5'd0:  v = 34'sh3243F6A8;
        5'd1:  v = 34'sh1DAC6705;
        5'd2:  v = 34'sh0FADBAFC;
        5'd3:  v = 34'sh07F56EA6;
        5'd4:  v = 34'sh03FEAB76;
        5'd5:  v = 34'sh01FFD55B;
        5'd6:  v = 34'sh00FFFAAA;
        5'd7:  v = 34'sh007FFF55;
        5'd8:  v = 34'sh003FFFEA;
        5'd9:  v = 34'sh001FFFFD;
        5'd10: v = 34'sh000FFFFF;
        5'd11: v = 34'sh0007FFFF;
        5'd12: v = 34'sh0003FFFF;
        5'd13: v = 34'sh0001FFFF;
        5'd14: v = 34'sh0000FFFF;
        5'd15: v = 34'sh00007FFF;
        5'd16: v = 34'sh00003FFF;
        5'd17: v = 34'sh00001FFF;
        5'd18: v = 34'sh00000FFF;
        5'd19: v = 34'sh000007FF;
        5'd20: v = 34'sh000003FF;
        5'd21: v = 34'sh000001FF;
        5'd22: v = 34'sh000000FF;
        5'd23: v = 34'sh0000007F;
        5'd24: v = 34'sh0000003F;
        5'd25: v = 34'sh0000001F;
        5'd26: v = 34'sh0000000F;
        5'd27: v = 34'sh00000008;
        5'd28: v = 34'sh00000004;
        5'd29: v = 34'sh00000002;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/gzt_front.sv @@
`default_nettype none
module gzt_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         in_kind,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic               in_has_fix,
  input  wire logic signed [30:0] in_latitude,
  input  wire logic signed [31:0] in_longitude,
  input  wire gzt_pkg::zone_t     in_override_zone,
  output logic                    q_push,
  output gzt_pkg::cmd_t           q_cmd,
  input  wire logic               q_full
);
  import gzt_pkg::*;

  zone_t       fz_r, fz_nxt;
  logic [31:0] fu_r, fu_nxt;
  logic [31:0] last_r, last_nxt;
  logic        expired;
  zone_t       fz_eff;

  assign full = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    fz_nxt = fz_r;
    fu_nxt = fu_r;
    last_nxt = last_r;
    expired = (fu_r != 32'd0) && (in_now_ms >= fu_r);
    fz_eff = expired ? ZONE_UNKNOWN : fz_r;
    q_cmd.op = OP_KEEP;
    q_cmd.zone = fz_eff;
    q_cmd.lat = in_latitude;
    q_cmd.lng = in_longitude;
    case (in_kind)
      KIND_TICK: begin
        if (expired) begin
          fz_nxt = ZONE_UNKNOWN;
          fu_nxt = 32'd0;
        end
        if (fz_eff != ZONE_UNKNOWN) begin
          q_cmd.op = OP_SET;
        end else if ((in_now_ms - last_r) >= CHECK_MS) begin
          last_nxt = in_now_ms;
          q_cmd.op = in_has_fix ? OP_SCAN : OP_KEEP;
        end
      end
      KIND_SET: begin
        fz_nxt = in_override_zone;
        fu_nxt = in_now_ms + OVERRIDE_MS;
      end
      KIND_CLEAR: begin
        fz_nxt = ZONE_UNKNOWN;
        fu_nxt = 32'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fz_r <= ZONE_UNKNOWN;
      fu_r <= 32'd0;
      last_r <= 32'd0;
    end else if (q_push) begin
      fz_r <= fz_nxt;
      fu_r <= fu_nxt;
      last_r <= last_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/gzt_queue.sv @@
`default_nettype none
module gzt_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire gzt_pkg::cmd_t din,
  output logic               full,
  input  wire logic          pop,
  output gzt_pkg::cmd_t      dout,
  output logic               empty
);
  import gzt_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_r <= !wr_r;
      end
      if (pop && !empty) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/gzt_cordic.sv @@
`default_nettype none
module gzt_cordic (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire gzt_pkg::cordic_req_t req,
  output gzt_pkg::cordic_rsp_t      rsp
);
  import gzt_pkg::*;

  cstate_t                 st_r, st_nxt;
  logic signed [ANG_W-1:0] r_r, r_nxt;
  logic [29:0]             a_r, a_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [COS_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [4:0]              it_r, it_nxt;
  logic                    done_r, done_nxt;
  logic signed [COS_W-1:0] cos_r, cos_nxt;
  logic signed [ANG_W-1:0] r1, r2, r3, r4, ab;
  logic [54:0]             zprod;
  logic signed [COS_W-1:0] dx, dy, at;

  assign rsp.done = done_r;
  assign rsp.cos = cos_r;

  always_comb begin
    st_nxt = st_r;
    r_nxt = r_r;
    a_nxt = a_r;
    neg_nxt = neg_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    it_nxt = it_r;
    done_nxt = 1'b0;
    cos_nxt = cos_r;
    r1 = (req.angle >= DEG_FULL) ? req.angle - DEG_FULL : req.angle;
    r2 = (r1 < 0) ? r1 + DEG_FULL : r1;
    r3 = (r2 < 0) ? r2 + DEG_FULL : r2;
    r4 = (r_r >= DEG_HALF) ? r_r - DEG_FULL : r_r;
    ab = (r4 < 0) ? -r4 : r4;
    zprod = 55'(a_r) * 55'(RAD_Q24) + 55'(1 << 23);
    dx = y_r >>> it_r;
    dy = x_r >>> it_r;
    at = atan_q30(it_r);
    case (st_r)
      C_IDLE: begin
        if (req.start) begin
          r_nxt = r3;
          st_nxt = C_FOLD;
        end
      end
      C_FOLD: begin
        neg_nxt = (ab > DEG_QUART);
        a_nxt = (ab > DEG_QUART) ? 30'(DEG_HALF - ab) : 30'(ab);
        st_nxt = C_MUL;
      end
      C_MUL: begin
        z_nxt = $signed({3'b000, zprod[54:24]});
        x_nxt = CORDIC_GAIN;
        y_nxt = '0;
        it_nxt = 5'd0;
        st_nxt = C_ITER;
      end
      C_ITER: begin
        if (z_r >= 0) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        it_nxt = it_r + 5'd1;
        if (it_r == 5'(CORDIC_ITERS - 1)) begin
          done_nxt = 1'b1;
          cos_nxt = neg_r ? -x_nxt : x_nxt;
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    a_r <= a_nxt;
    neg_r <= neg_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    it_r <= it_nxt;
    cos_r <= cos_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/gzt_back.sv @@
`default_nettype none
module gzt_back #(
  parameter int NUM_FENCES = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  wire gzt_pkg::cmd_t        q_dout,
  output logic                      q_pop,
  input  wire gzt_pkg::fpos_t       fence_pos [gzt_pkg::MAX_FENCES],
  input  wire gzt_pkg::farea_t      fence_area [gzt_pkg::MAX_FENCES],
  output gzt_pkg::cordic_req_t      creq,
  input  wire gzt_pkg::cordic_rsp_t crsp,
  output logic                      empty,
  input  wire logic                 pop,
  output gzt_pkg::zone_t            out_zone
);
  import gzt_pkg::*;

  bstate_t                 st_r, st_nxt;
  zone_t                   cur_r, cur_nxt;
  logic signed [30:0]      lat_r, lat_nxt;
  logic signed [31:0]      lng_r, lng_nxt;
  logic [FK_W-1:0]         fk_r, fk_nxt;
  logic [2:0]              cidx_r, cidx_nxt;
  logic [30:0]             rang_r, rang_nxt;
  logic signed [COS_W-1:0] cosv_r [5];
  logic signed [COS_W-1:0] p_r, p_nxt;
  logic signed [COS_W:0]   q_r, q_nxt;
  logic                    ov_r, ov_nxt;
  zone_t                   oz_r, oz_nxt;
  fpos_t                   pos;
  farea_t                  area;
  logic signed [31:0]      lat2, lng2;
  logic                    last_fence;
  logic [46:0]             rprod;
  logic signed [67:0]      m1;
  logic signed [68:0]      m2;
  logic signed [COS_W+1:0] lhs, rhs;

  assign empty = !ov_r;
  assign out_zone = oz_r;
  assign pos = fence_pos[fk_r];
  assign area = fence_area[fk_r];
  assign lat2 = $signed(pos[63:32]);
  assign lng2 = $signed(pos[31:0]);
  assign last_fence = (fk_r == FK_W'(NUM_FENCES - 1));

  always_comb begin
    st_nxt = st_r;
    cur_nxt = cur_r;
    lat_nxt = lat_r;
    lng_nxt = lng_r;
    fk_nxt = fk_r;
    cidx_nxt = cidx_r;
    rang_nxt = rang_r;
    p_nxt = p_r;
    q_nxt = q_r;
    ov_nxt = ov_r && !pop;
    oz_nxt = oz_r;
    q_pop = 1'b0;
    creq.start = 1'b0;
    case (cidx_r)
      3'd0: creq.angle = ANG_W'(lat2) - ANG_W'(lat_r);
      3'd1: creq.angle = ANG_W'(lng2) - ANG_W'(lng_r);
      3'd2: creq.angle = ANG_W'(lat_r);
      3'd3: creq.angle = ANG_W'(lat2);
      default: creq.angle = $signed({4'b0000, rang_r});
    endcase
    rprod = 47'(area[23:0]) * 47'(M_TO_DEG_Q16) + 47'(1 << 15);
    m1 = 68'(cosv_r[2]) * 68'(cosv_r[3]);
    m2 = 69'(p_r) * 69'(ONE_Q30 - 35'(cosv_r[1]));
    lhs = 36'(ONE_Q30 - 35'(cosv_r[0])) + 36'(q_r);
    rhs = 36'(ONE_Q30 - 35'(cosv_r[4]));
    case (st_r)
      B_IDLE: begin
        if (!q_empty && !ov_r) begin
          q_pop = 1'b1;
          case (q_dout.op)
            OP_SET: begin
              cur_nxt = q_dout.zone;
              ov_nxt = 1'b1;
              oz_nxt = q_dout.zone;
            end
            OP_SCAN: begin
              lat_nxt = q_dout.lat;
              lng_nxt = q_dout.lng;
              fk_nxt = '0;
              st_nxt = B_FENCE;
            end
            default: begin
              ov_nxt = 1'b1;
              oz_nxt = cur_r;
            end
          endcase
        end
      end
      B_FENCE: begin
        if (area[23:0] == 24'd0) begin
          if (last_fence) begin
            cur_nxt = ZONE_UNKNOWN;
            ov_nxt = 1'b1;
            oz_nxt = ZONE_UNKNOWN;
            st_nxt = B_IDLE;
          end else begin
            fk_nxt = fk_r + FK_W'(1);
          end
        end else begin
          rang_nxt = rprod[46:16];
          cidx_nxt = 3'd0;
          st_nxt = B_START;
        end
      end
      B_START: begin
        creq.start = 1'b1;
        st_nxt = B_WAIT;
      end
      B_WAIT: begin
        if (crsp.done) begin
          if (cidx_r == 3'd4) begin
            st_nxt = B_P;
          end else begin
            cidx_nxt = cidx_r + 3'd1;
            st_nxt = B_START;
          end
        end
      end
      B_P: begin
        p_nxt = m1[63:30];
        st_nxt = B_Q;
      end
      B_Q: begin
        q_nxt = m2[64:30];
        st_nxt = B_CMP;
      end
      B_CMP: begin
        if (lhs <= rhs) begin
          cur_nxt = area[25:24];
          ov_nxt = 1'b1;
          oz_nxt = area[25:24];
          st_nxt = B_IDLE;
        end else if (last_fence) begin
          cur_nxt = ZONE_UNKNOWN;
          ov_nxt = 1'b1;
          oz_nxt = ZONE_UNKNOWN;
          st_nxt = B_IDLE;
        end else begin
          fk_nxt = fk_r + FK_W'(1);
          st_nxt = B_FENCE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      cur_r <= ZONE_HOME;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cur_r <= cur_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lat_r <= lat_nxt;
    lng_r <= lng_nxt;
    fk_r <= fk_nxt;
    cidx_r <= cidx_nxt;
    rang_r <= rang_nxt;
    p_r <= p_nxt;
    q_r <= q_nxt;
    oz_r <= oz_nxt;
    if (st_r == B_WAIT && crsp.done) begin
      cosv_r[cidx_r] <= crsp.cos;
    end
  end

  // A result is only produced in idle or on the way back to idle, so it is never waiting mid-scan.
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != B_IDLE |-> !ov_r) else $error("result pending during fence scan");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    crsp.done |-> st_r == B_WAIT) else $error("cosine done outside wait state");

  a_cidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_START || st_r == B_WAIT) |-> cidx_r <= 3'd4) else $error("cosine index overrun");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    creq.start |=> $past(st_r) == B_START && !crsp.done) else $error("bad cosine start");

endmodule
`default_nettype wire

@@ hw/rtl/geofence_zone_tracker_top.sv @@
`default_nettype none
// A transaction that needs no fence scan is written into the queue, then popped by the back end,
// which registers its result on out_zone. A scan computes five cosines per enabled fence checked,
// one after another on the single CORDIC unit, plus the distance compare; zero-radius fences are skipped.
// The back end takes the next transaction only when idle and after its last result has been popped.
// A two-entry queue lets the input side accept transactions while a scan runs.
// Reset (rst_n low, synchronous) clears all fences, the override and the zone to home.
module geofence_zone_tracker_top #(
  parameter int NUM_FENCES = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         in_kind,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic               in_has_fix,
  input  wire logic signed [30:0] in_latitude,
  input  wire logic signed [31:0] in_longitude,
  input  wire logic [1:0]         in_override_zone,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              out_zone,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  import gzt_pkg::*;

  fpos_t       fpos_r [MAX_FENCES];
  farea_t      farea_r [MAX_FENCES];
  logic [2:0]  ridx;
  logic        q_push, q_full, q_pop, q_empty;
  cmd_t        q_din, q_dout;
  cordic_req_t creq;
  cordic_rsp_t crsp;

  assign pready = 1'b1;
  assign ridx = paddr[5:3];
  assign prdata = ridx[0] ? 64'(farea_r[ridx[2:1]]) : fpos_r[ridx[2:1]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_FENCES; k++) begin
        fpos_r[k] <= '0;
        farea_r[k] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      if (ridx[0]) begin
        farea_r[ridx[2:1]] <= pwdata[25:0];
      end else begin
        fpos_r[ridx[2:1]] <= pwdata;
      end
    end
  end

  gzt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_kind          (in_kind),
    .in_now_ms        (in_now_ms),
    .in_has_fix       (in_has_fix),
    .in_latitude      (in_latitude),
    .in_longitude     (in_longitude),
    .in_override_zone (in_override_zone),
    .q_push           (q_push),
    .q_cmd            (q_din),
    .q_full           (q_full)
  );

  gzt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  gzt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  gzt_back #(
    .NUM_FENCES (NUM_FENCES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .fence_pos  (fpos_r),
    .fence_area (farea_r),
    .creq       (creq),
    .crsp       (crsp),
    .empty      (empty),
    .pop        (pop),
    .out_zone   (out_zone)
  );

endmodule
`default_nettype wire
